FILE: rtl/core/mpba_pkg.sv
// ============================================================================
// mpba_pkg
// Shared types and constants of the multi-pool bump allocator.
// ============================================================================
`default_nettype none

package mpba_pkg;

  // Fixed geometry of the allocator
  localparam int POOL_BYTES   = 8192;
  localparam int POOL_COUNT   = 4;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 4;

  localparam int SIZE_W  = 14;
  localparam int ADDR_W  = 15;
  localparam int POOL_W  = 2;
  localparam int OFF_W   = 13;
  localparam int REQ_W   = 16;
  localparam int NEED_W  = 18;
  localparam int CNT_W   = 32;
  localparam int TAG_W   = 2;
  localparam int TAG_DEPTH = (POOL_COUNT * POOL_BYTES) / ALIGN_BYTES;
  localparam int TAG_AW  = $clog2(TAG_DEPTH);
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

  // Header tag codes
  localparam logic [TAG_W-1:0] TAG_NONE  = 2'd0;
  localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_FREED = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_ROOM  = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_BAD_FREE = 3'd3;
  localparam logic [2:0] ST_DBL_FREE = 3'd4;

  // Register indexes (word address)
  localparam logic [2:0] REG_POOL_SIZE_0 = 3'd0;
  localparam logic [2:0] REG_POOL_SIZE_1 = 3'd1;
  localparam logic [2:0] REG_POOL_SIZE_2 = 3'd2;
  localparam logic [2:0] REG_POOL_SIZE_3 = 3'd3;
  localparam logic [2:0] REG_DEFRAG_EN   = 3'd4;

  typedef enum logic [1:0] {
    OP_ALLOC       = 2'd0,
    OP_FREE        = 2'd1,
    OP_DEFRAG      = 2'd2,
    OP_RESET_STATS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Configuration seen by the core
  typedef struct packed {
    logic [POOL_COUNT-1:0][SIZE_W-1:0] size;
    logic                              defrag_en;
  } cfg_t;

  // One entry of the per-pool statistics memory
  typedef struct packed {
    logic [SIZE_W-1:0] fill;
    logic [SIZE_W-1:0] peak;
    logic [CNT_W-1:0]  allocs;
    logic [CNT_W-1:0]  frees;
    logic [CNT_W-1:0]  fails;
  } pool_stats_t;

  typedef struct packed {
    logic              we;
    logic [POOL_W-1:0] addr;
    pool_stats_t       data;
  } stats_wr_t;

  typedef struct packed {
    logic              we;
    logic [TAG_AW-1:0] addr;
    logic [TAG_W-1:0]  data;
  } tag_wr_t;

  // Registered result of one request
  typedef struct packed {
    logic              done;
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [POOL_W-1:0] acted_pool;
    logic              pool_mismatch;
    logic [SIZE_W-1:0] reclaimed_bytes;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] peak_bytes;
    logic [CNT_W-1:0]  alloc_total;
    logic [CNT_W-1:0]  free_total;
    logic [CNT_W-1:0]  fail_total;
    logic [CNT_W-1:0]  active_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/mpba_ram.sv
// ============================================================================
// mpba_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpba_cfg.sv
// ============================================================================
// mpba_cfg
// APB register file: pool sizes and the defrag enable.
// ============================================================================
`default_nettype none

module mpba_cfg
  import mpba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size[0]   <= 14'd8192;
      cfg.size[1]   <= 14'd4096;
      cfg.size[2]   <= 14'd4096;
      cfg.size[3]   <= 14'd0;
      cfg.defrag_en <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POOL_SIZE_0: cfg.size[0]   <= pwdata[SIZE_W-1:0];
        REG_POOL_SIZE_1: cfg.size[1]   <= pwdata[SIZE_W-1:0];
        REG_POOL_SIZE_2: cfg.size[2]   <= pwdata[SIZE_W-1:0];
        REG_POOL_SIZE_3: cfg.size[3]   <= pwdata[SIZE_W-1:0];
        REG_DEFRAG_EN:   cfg.defrag_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_POOL_SIZE_0: prdata = {18'd0, cfg.size[0]};
      REG_POOL_SIZE_1: prdata = {18'd0, cfg.size[1]};
      REG_POOL_SIZE_2: prdata = {18'd0, cfg.size[2]};
      REG_POOL_SIZE_3: prdata = {18'd0, cfg.size[3]};
      REG_DEFRAG_EN:   prdata = {31'd0, cfg.defrag_en};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpba_core.sv
// ============================================================================
// mpba_core
// Request sequencer and read-modify-write datapath over the stats and tag
// memories, including the clearing pass after reset.
// ============================================================================
`default_nettype none

module mpba_core
  import mpba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op,
  input  wire logic [2:0]         pool,
  input  wire logic [REQ_W-1:0]   request_size,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire cfg_t               cfg,
  output logic      [POOL_W-1:0]  stats_raddr,
  input  wire pool_stats_t        stats_rdata,
  output stats_wr_t               stats_wr,
  output logic      [TAG_AW-1:0]  tag_raddr,
  input  wire logic [TAG_W-1:0]   tag_rdata,
  output tag_wr_t                 tag_wr,
  output rsp_t                    rsp
);

  state_t            state, state_next;
  logic [TAG_AW-1:0] clr_cnt;
  logic              accept;

  // Request held for the execute cycle
  op_t               op_q;
  logic [2:0]        named_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [POOL_W-1:0] p_q;

  // Accept-side lookups
  logic              named_ok_in;
  logic [POOL_W-1:0] p_in;
  logic [ADDR_W-1:0] hdr_in;

  // Execute-cycle datapath
  pool_stats_t       st, st_next;
  logic [SIZE_W-1:0] size_raw, sz;
  logic              pool_en, named_ok;
  logic [NEED_W-1:0] need, room;
  logic [ADDR_W-1:0] base, hdr_q;
  logic [OFF_W-1:0]  off;
  logic              free_bad;
  logic [2:0]        status;
  logic [ADDR_W-1:0] res_addr;
  logic              mismatch;
  logic [SIZE_W-1:0] reclaimed;
  logic              tag_we;
  logic [TAG_W-1:0]  tag_wdata;
  logic [TAG_AW-1:0] tag_waddr;

  assign accept = start && !busy;

  // Resolve the acted pool and header index from the ports
  always_comb begin
    named_ok_in = (pool < 3'(POOL_COUNT)) && (cfg.size[pool[POOL_W-1:0]] != '0);
    hdr_in      = address - ADDR_W'(HEADER_BYTES);
    case (op_t'(op))
      OP_ALLOC: p_in = named_ok_in ? pool[POOL_W-1:0] : '0;
      OP_FREE:  p_in = address[ADDR_W-1:OFF_W];
      default:  p_in = (pool < 3'(POOL_COUNT)) ? pool[POOL_W-1:0] : '0;
    endcase
  end

  assign stats_raddr = p_in;
  assign tag_raddr   = hdr_in[ADDR_W-1:ALIGN_SH];

  // State register and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Next state and busy
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == TAG_AW'(TAG_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(op);
      named_q <= pool;
      req_q   <= request_size;
      addr_q  <= address;
      p_q     <= p_in;
    end
  end

  // Execute: modify the stats entry and decide the tag update
  always_comb begin
    st        = stats_rdata;
    st_next   = st;
    size_raw  = cfg.size[p_q];
    sz        = (size_raw > SIZE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES) : size_raw;
    pool_en   = (size_raw != '0);
    named_ok  = (named_q < 3'(POOL_COUNT)) && (cfg.size[named_q[POOL_W-1:0]] != '0);
    need      = ((NEED_W'(req_q) + NEED_W'(ALIGN_BYTES - 1)) & ~NEED_W'(ALIGN_BYTES - 1))
                + NEED_W'(HEADER_BYTES);
    room      = NEED_W'(sz) - NEED_W'(st.fill);
    base      = {p_q, st.fill[OFF_W-1:0]};
    off       = addr_q[OFF_W-1:0];
    hdr_q     = addr_q - ADDR_W'(HEADER_BYTES);
    free_bad  = !pool_en || ({1'b0, off} >= sz) || (off < OFF_W'(HEADER_BYTES)) ||
                (addr_q[ALIGN_SH-1:0] != '0);
    status    = ST_OK;
    res_addr  = '0;
    mismatch  = 1'b0;
    reclaimed = '0;
    tag_we    = 1'b0;
    tag_wdata = TAG_LIVE;
    tag_waddr = base[ADDR_W-1:ALIGN_SH];
    case (op_q)
      OP_ALLOC: begin
        if (req_q == '0 || !pool_en) begin
          status = ST_REJECTED;
        end else if (st.fill > sz || need > room) begin
          status        = ST_NO_ROOM;
          st_next.fails = st.fails + 1'b1;
        end else begin
          tag_we         = 1'b1;
          res_addr       = base + ADDR_W'(HEADER_BYTES);
          st_next.fill   = st.fill + need[SIZE_W-1:0];
          st_next.allocs = st.allocs + 1'b1;
          if (st_next.fill > st.peak) begin
            st_next.peak = st_next.fill;
          end
        end
      end
      OP_FREE: begin
        tag_waddr = hdr_q[ADDR_W-1:ALIGN_SH];
        tag_wdata = TAG_FREED;
        if (free_bad || (tag_rdata != TAG_LIVE && tag_rdata != TAG_FREED)) begin
          status = ST_BAD_FREE;
        end else begin
          mismatch = named_ok && (named_q[POOL_W-1:0] != p_q || named_q >= 3'(POOL_COUNT));
          if (tag_rdata == TAG_FREED) begin
            status = ST_DBL_FREE;
          end else begin
            tag_we = 1'b1;
            if (st.frees < st.allocs) begin
              st_next.frees = st.frees + 1'b1;
            end
          end
        end
      end
      OP_DEFRAG: begin
        if (!named_ok || !cfg.defrag_en) begin
          status = ST_REJECTED;
        end else if (st.allocs == st.frees) begin
          reclaimed    = st.fill;
          st_next.fill = '0;
        end
      end
      default: begin
        if (!named_ok) begin
          status = ST_REJECTED;
        end else begin
          st_next.peak   = st.fill;
          st_next.allocs = '0;
          st_next.frees  = '0;
          st_next.fails  = '0;
        end
      end
    endcase
  end

  // Drive the memory write ports: clearing pass or write-back
  always_comb begin
    stats_wr.we   = 1'b0;
    stats_wr.addr = p_q;
    stats_wr.data = st_next;
    tag_wr.we     = 1'b0;
    tag_wr.addr   = tag_waddr;
    tag_wr.data   = tag_wdata;
    if (state == S_CLEAR) begin
      stats_wr.we   = (clr_cnt < TAG_AW'(POOL_COUNT));
      stats_wr.addr = clr_cnt[POOL_W-1:0];
      stats_wr.data = '0;
      tag_wr.we     = 1'b1;
      tag_wr.addr   = clr_cnt;
      tag_wr.data   = TAG_NONE;
    end else if (state == S_EXEC) begin
      stats_wr.we = 1'b1;
      tag_wr.we   = tag_we;
    end
  end

  // Result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_EXEC);
    end
    if (state == S_EXEC) begin
      rsp.status          <= status;
      rsp.result_address  <= res_addr;
      rsp.acted_pool      <= p_q;
      rsp.pool_mismatch   <= mismatch;
      rsp.reclaimed_bytes <= reclaimed;
      rsp.used_bytes      <= st_next.fill;
      rsp.free_bytes      <= (sz > st_next.fill) ? (sz - st_next.fill) : '0;
      rsp.peak_bytes      <= st_next.peak;
      rsp.alloc_total     <= st_next.allocs;
      rsp.free_total      <= st_next.frees;
      rsp.fail_total      <= st_next.fails;
      rsp.active_count    <= (st_next.allocs >= st_next.frees) ?
                             (st_next.allocs - st_next.frees) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/multi_pool_bump_allocator_top.sv
// ============================================================================
// multi_pool_bump_allocator_top
// Four bump pools with header tags, per-pool statistics and defrag.
// ============================================================================
// Usage:
//   Requests enter on start/op/pool/request_size/address and are taken at a
//   rising edge where start is high and busy is low. Each request yields one
//   result, shown for one cycle with done high; the receiver cannot stall and
//   must take it then.
//   The accepting edge moves the request into the execute state, and the
//   result registers load from that state and raise done. Busy holds off
//   the next request until the previous one leaves the execute state, so
//   the read-modify-write of the stats and tag memories (registered read on
//   accept, write-back in execute) completes and the next read sees it.
//   Reset: rst clears the control state, loads the register defaults and
//   starts a clearing pass that writes every header tag to
//   none and zeroes the pool statistics; busy is high for that pass. The
//   APB port takes writes at any time, but registers should change only
//   while the block is idle.
// ============================================================================
`default_nettype none

module multi_pool_bump_allocator_top
  import mpba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op,
  input  wire logic [2:0]         pool,
  input  wire logic [REQ_W-1:0]   request_size,
  input  wire logic [ADDR_W-1:0]  address,
  // result channel
  output logic                    done,
  output logic      [2:0]         status,
  output logic      [ADDR_W-1:0]  result_address,
  output logic      [POOL_W-1:0]  acted_pool,
  output logic                    pool_mismatch,
  output logic      [SIZE_W-1:0]  reclaimed_bytes,
  output logic      [SIZE_W-1:0]  used_bytes,
  output logic      [SIZE_W-1:0]  free_bytes,
  output logic      [SIZE_W-1:0]  peak_bytes,
  output logic      [CNT_W-1:0]   alloc_total,
  output logic      [CNT_W-1:0]   free_total,
  output logic      [CNT_W-1:0]   fail_total,
  output logic      [CNT_W-1:0]   active_count,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int StatsW = $bits(pool_stats_t);

  cfg_t              cfg;
  logic [POOL_W-1:0] stats_raddr;
  pool_stats_t       stats_rdata;
  stats_wr_t         stats_wr;
  logic [TAG_AW-1:0] tag_raddr;
  logic [TAG_W-1:0]  tag_rdata;
  tag_wr_t           tag_wr;
  rsp_t              rsp;

  mpba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-pool statistics
  mpba_ram #(
    .WIDTH (StatsW),
    .DEPTH (POOL_COUNT)
  ) u_stats_ram (
    .clk   (clk),
    .we    (stats_wr.we),
    .waddr (stats_wr.addr),
    .wdata (stats_wr.data),
    .raddr (stats_raddr),
    .rdata (stats_rdata)
  );

  // Header tags, one per aligned word of address space
  mpba_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_wr.we),
    .waddr (tag_wr.addr),
    .wdata (tag_wr.data),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  mpba_core u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .pool         (pool),
    .request_size (request_size),
    .address      (address),
    .cfg          (cfg),
    .stats_raddr  (stats_raddr),
    .stats_rdata  (stats_rdata),
    .stats_wr     (stats_wr),
    .tag_raddr    (tag_raddr),
    .tag_rdata    (tag_rdata),
    .tag_wr       (tag_wr),
    .rsp          (rsp)
  );

  // Unpack the result
  assign done            = rsp.done;
  assign status          = rsp.status;
  assign result_address  = rsp.result_address;
  assign acted_pool      = rsp.acted_pool;
  assign pool_mismatch   = rsp.pool_mismatch;
  assign reclaimed_bytes = rsp.reclaimed_bytes;
  assign used_bytes      = rsp.used_bytes;
  assign free_bytes      = rsp.free_bytes;
  assign peak_bytes      = rsp.peak_bytes;
  assign alloc_total     = rsp.alloc_total;
  assign free_total      = rsp.free_total;
  assign fail_total      = rsp.fail_total;
  assign active_count    = rsp.active_count;

endmodule

`default_nettype wire

FILE: rtl/core/mpba_checker.sv
// ============================================================================
// mpba_checker
// Port-level checks of the allocator's request/result timing and results.
// ============================================================================
`default_nettype none

module mpba_checker
  import mpba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [2:0]        status,
  input wire logic [ADDR_W-1:0] result_address,
  input wire logic [SIZE_W-1:0] reclaimed_bytes,
  input wire logic [SIZE_W-1:0] used_bytes,
  input wire logic [SIZE_W-1:0] peak_bytes
);

  // An accepted request holds off the next one for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted request");

  // Every accepted request gets its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing two cycles after accept");

  // Results are single-cycle strobes
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Failed requests return no address and reclaim nothing
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_address == '0 && reclaimed_bytes == '0))
    else $error("failed request returned an address or reclaimed bytes");

  // Fill level never passes the recorded peak
  a_fill_le_peak: assert property (@(posedge clk) disable iff (rst)
    done |-> (used_bytes <= peak_bytes))
    else $error("fill level above peak");

endmodule

bind multi_pool_bump_allocator_top mpba_checker u_mpba_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .result_address  (result_address),
  .reclaimed_bytes (reclaimed_bytes),
  .used_bytes      (used_bytes),
  .peak_bytes      (peak_bytes)
);

`default_nettype wire

FILE: tb/multi_pool_bump_allocator_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// multi_pool_bump_allocator_top_test
// Self-checking bench for the four-pool bump allocator.
// ============================================================================
// A queue of requests, filled phase by phase from the main initial block,
// feeds a clocked driver with random gaps. Every accepted request runs
// through a local model of the pools and header tags, and a clocked monitor
// compares each done strobe, field by field, with the oldest prediction.
// Pool sizes and defrag enable change over the APB port between phases,
// always with the block drained.
// ============================================================================

module multi_pool_bump_allocator_top_test;
  import mpba_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 285;
  localparam int GRANT_KEEP     = 64;
  localparam int MAX_REPORTS    = 120;

  typedef struct {
    op_t               op;
    logic [2:0]        pool;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] address;
    bit                from_grant;   // free a recently granted address
    bit                drain_first;  // hold until all results are back
  } pool_request_t;

  typedef struct {
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [POOL_W-1:0] acted_pool;
    logic              pool_mismatch;
    logic [SIZE_W-1:0] reclaimed_bytes;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] peak_bytes;
    logic [CNT_W-1:0]  alloc_total;
    logic [CNT_W-1:0]  free_total;
    logic [CNT_W-1:0]  fail_total;
    logic [CNT_W-1:0]  active_count;
  } pool_outcome_t;

  // Clock, reset and block inputs
  logic              clk;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic [1:0]        op           = OP_ALLOC;
  logic [2:0]        pool         = '0;
  logic [REQ_W-1:0]  request_size = '0;
  logic [ADDR_W-1:0] address      = '0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [4:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;

  // Block outputs
  logic              busy;
  logic              done;
  logic [2:0]        status;
  logic [ADDR_W-1:0] result_address;
  logic [POOL_W-1:0] acted_pool;
  logic              pool_mismatch;
  logic [SIZE_W-1:0] reclaimed_bytes;
  logic [SIZE_W-1:0] used_bytes;
  logic [SIZE_W-1:0] free_bytes;
  logic [SIZE_W-1:0] peak_bytes;
  logic [CNT_W-1:0]  alloc_total;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  fail_total;
  logic [CNT_W-1:0]  active_count;
  logic [31:0]       prdata;
  logic              pready;

  multi_pool_bump_allocator_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .pool            (pool),
    .request_size    (request_size),
    .address         (address),
    .done            (done),
    .status          (status),
    .result_address  (result_address),
    .acted_pool      (acted_pool),
    .pool_mismatch   (pool_mismatch),
    .reclaimed_bytes (reclaimed_bytes),
    .used_bytes      (used_bytes),
    .free_bytes      (free_bytes),
    .peak_bytes      (peak_bytes),
    .alloc_total     (alloc_total),
    .free_total      (free_total),
    .fail_total      (fail_total),
    .active_count    (active_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Model state of the pools and the header tags
  int unsigned       cfg_size [POOL_COUNT];
  bit                defrag_on;
  int unsigned       fill [POOL_COUNT];
  int unsigned       peak [POOL_COUNT];
  logic [CNT_W-1:0]  allocs [POOL_COUNT];
  logic [CNT_W-1:0]  frees [POOL_COUNT];
  logic [CNT_W-1:0]  fails [POOL_COUNT];
  logic [TAG_W-1:0]  tag_store [TAG_DEPTH];

  pool_request_t     request_q [$];
  pool_outcome_t     outcome_q [$];
  logic [ADDR_W-1:0] granted_addrs [$];
  pool_request_t     cur_req;
  int                gap_left = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Pool model
  // --------------------------------------------------------------------------
  task automatic pool_model_reset();
    cfg_size[0] = 8192;
    cfg_size[1] = 4096;
    cfg_size[2] = 4096;
    cfg_size[3] = 0;
    defrag_on = 1'b0;
    for (int i = 0; i < POOL_COUNT; i++) begin
      fill[i] = 0;
      peak[i] = 0;
      allocs[i] = '0;
      frees[i] = '0;
      fails[i] = '0;
    end
    for (int i = 0; i < TAG_DEPTH; i++) tag_store[i] = TAG_NONE;
  endtask

  // Sizes above the window act as the full window
  function automatic int unsigned eff_size(int unsigned p);
    if (p >= POOL_COUNT) return 0;
    return (cfg_size[p] > POOL_BYTES) ? POOL_BYTES : cfg_size[p];
  endfunction

  function automatic bit pool_enabled(int unsigned p);
    return (p < POOL_COUNT) && (eff_size(p) > 0);
  endfunction

  function automatic pool_outcome_t pool_report(int unsigned p, logic [2:0] st,
                                                int unsigned ra, bit mm,
                                                int unsigned rec);
    pool_outcome_t o;
    int unsigned   sz;
    sz = eff_size(p);
    o.status          = st;
    o.result_address  = ra[ADDR_W-1:0];
    o.acted_pool      = p[POOL_W-1:0];
    o.pool_mismatch   = mm;
    o.reclaimed_bytes = rec[SIZE_W-1:0];
    o.used_bytes      = fill[p][SIZE_W-1:0];
    o.free_bytes      = (sz > fill[p]) ? SIZE_W'(sz - fill[p]) : '0;
    o.peak_bytes      = peak[p][SIZE_W-1:0];
    o.alloc_total     = allocs[p];
    o.free_total      = frees[p];
    o.fail_total      = fails[p];
    o.active_count    = (allocs[p] >= frees[p]) ? allocs[p] - frees[p] : '0;
    return o;
  endfunction

  // Apply one accepted request to the model and return its result
  function automatic pool_outcome_t bump_pool_step(pool_request_t rq);
    int unsigned named, p, sz, f, need, base, addr, owner, off, hdr, idx, rec;
    logic [TAG_W-1:0] tag;
    bit mm;
    named = rq.pool;
    case (rq.op)
      OP_ALLOC: begin
        p = pool_enabled(named) ? named : 0;
        if (rq.request_size == 0 || !pool_enabled(p))
          return pool_report(p, ST_REJECTED, 0, 0, 0);
        sz = eff_size(p);
        f = fill[p];
        need = HEADER_BYTES +
               ((rq.request_size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        // A size lowered under the fill level leaves no room either
        if (f > sz || need > sz - f) begin
          fails[p] = fails[p] + 1;
          return pool_report(p, ST_NO_ROOM, 0, 0, 0);
        end
        base = p * POOL_BYTES + f;
        tag_store[(base / ALIGN_BYTES) % TAG_DEPTH] = TAG_LIVE;
        fill[p] = f + need;
        allocs[p] = allocs[p] + 1;
        if (fill[p] > peak[p]) peak[p] = fill[p];
        granted_addrs.push_back(ADDR_W'(base + HEADER_BYTES));
        if (granted_addrs.size() > GRANT_KEEP) void'(granted_addrs.pop_front());
        return pool_report(p, ST_OK, base + HEADER_BYTES, 0, 0);
      end
      OP_FREE: begin
        addr = rq.address;
        owner = addr / POOL_BYTES;
        off = addr % POOL_BYTES;
        hdr = addr - ((off >= HEADER_BYTES) ? HEADER_BYTES : 0);
        if (!pool_enabled(owner) || off >= eff_size(owner) || off < HEADER_BYTES ||
            (hdr % ALIGN_BYTES) != 0)
          return pool_report(owner, ST_BAD_FREE, 0, 0, 0);
        idx = (hdr / ALIGN_BYTES) % TAG_DEPTH;
        tag = tag_store[idx];
        if (tag != TAG_LIVE && tag != TAG_FREED)
          return pool_report(owner, ST_BAD_FREE, 0, 0, 0);
        mm = pool_enabled(named) && (named != owner);
        if (tag == TAG_FREED) return pool_report(owner, ST_DBL_FREE, 0, mm, 0);
        tag_store[idx] = TAG_FREED;
        // Free count saturates at the alloc count
        if (frees[owner] < allocs[owner]) frees[owner] = frees[owner] + 1;
        return pool_report(owner, ST_OK, 0, mm, 0);
      end
      default: begin
        p = (named < POOL_COUNT) ? named : 0;
        if (!pool_enabled(named) || (rq.op == OP_DEFRAG && !defrag_on))
          return pool_report(p, ST_REJECTED, 0, 0, 0);
        if (rq.op == OP_DEFRAG) begin
          rec = 0;
          if (allocs[p] == frees[p]) begin
            rec = fill[p];
            fill[p] = 0;
          end
          return pool_report(p, ST_OK, 0, 0, rec);
        end
        peak[p] = fill[p];
        allocs[p] = '0;
        frees[p] = '0;
        fails[p] = '0;
        return pool_report(p, ST_OK, 0, 0, 0);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued requests with random gaps
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    pool_request_t nxt;
    bit took;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        outcome_q.push_back(bump_pool_step(cur_req));
        gap_left = pick_gap();
      end
      if (start && !took) begin
        // hold the current request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() > 0 &&
                   (!request_q[0].drain_first || outcome_q.size() == 0)) begin
        nxt = request_q.pop_front();
        if (nxt.from_grant && granted_addrs.size() > 0)
          nxt.address = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
        cur_req = nxt;
        start <= 1'b1;
        op <= nxt.op;
        pool <= nxt.pool;
        request_size <= nxt.request_size;
        address <= nxt.address;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pool_outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request waiting, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = outcome_q.pop_front();
        compare_field("status", want.status, status);
        compare_field("result_address", want.result_address, result_address);
        compare_field("acted_pool", want.acted_pool, acted_pool);
        compare_field("pool_mismatch", want.pool_mismatch, pool_mismatch);
        compare_field("reclaimed_bytes", want.reclaimed_bytes, reclaimed_bytes);
        compare_field("used_bytes", want.used_bytes, used_bytes);
        compare_field("free_bytes", want.free_bytes, free_bytes);
        compare_field("peak_bytes", want.peak_bytes, peak_bytes);
        compare_field("alloc_total", want.alloc_total, alloc_total);
        compare_field("free_total", want.free_total, free_total);
        compare_field("fail_total", want.fail_total, fail_total);
        compare_field("active_count", want.active_count, active_count);
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_pool_bump_allocator_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_request(op_t o, int unsigned pl, int unsigned rq, int unsigned ad);
    pool_request_t it;
    it.op = o;
    it.pool = pl[2:0];
    it.request_size = rq[REQ_W-1:0];
    it.address = ad[ADDR_W-1:0];
    it.from_grant = 1'b0;
    it.drain_first = 1'b0;
    request_q.push_back(it);
  endtask

  task automatic queue_random_request();
    pool_request_t it;
    int unsigned r, s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    it.pool = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, 3));
    it.address = ADDR_W'($urandom);
    it.from_grant = 1'b0;
    // Mostly small allocations so pools fill gradually
    if (s < 5) it.request_size = '0;
    else if (s < 75) it.request_size = REQ_W'($urandom_range(1, 256));
    else if (s < 90) it.request_size = REQ_W'($urandom_range(257, 2048));
    else it.request_size = REQ_W'($urandom);
    if (r < 45) begin
      it.op = OP_ALLOC;
    end else if (r < 80) begin
      it.op = OP_FREE;
      it.from_grant = ($urandom_range(0, 4) != 0);
    end else if (r < 92) begin
      it.op = OP_DEFRAG;
    end else begin
      it.op = OP_RESET_STATS;
    end
    it.drain_first = ($urandom_range(0, 99) == 0);
    request_q.push_back(it);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DEFRAG_EN) defrag_on = val[0];
    else cfg_size[idx] = val & 32'h3FFF;
  endtask

  task automatic write_config(int unsigned s0, int unsigned s1, int unsigned s2,
                              int unsigned s3, bit den);
    write_reg(REG_POOL_SIZE_0, s0);
    write_reg(REG_POOL_SIZE_1, s1);
    write_reg(REG_POOL_SIZE_2, s2);
    write_reg(REG_POOL_SIZE_3, s3);
    write_reg(REG_DEFRAG_EN, den);
  endtask

  // Wait until every request is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk); while (request_q.size() != 0 || start || outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_pool_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 40) return POOL_BYTES;
    if (r < 48) return 16383;
    if (r < 65) return $urandom_range(0, 16383);
    return $urandom_range(64, 2048);
  endfunction

  initial begin
    pool_model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Default sizes: zero request, fallback, no room, every kind of bad free
    queue_request(OP_ALLOC, 0, 0, 0);
    queue_request(OP_ALLOC, 0, 1, 0);
    queue_request(OP_ALLOC, 1, 65535, 0);
    queue_request(OP_ALLOC, 3, 8, 0);
    queue_request(OP_ALLOC, 7, 5, 0);
    queue_request(OP_FREE, 1, 0, 16);
    queue_request(OP_FREE, 0, 0, 16);
    queue_request(OP_FREE, 2, 0, 0);
    queue_request(OP_FREE, 0, 0, 18);
    queue_request(OP_FREE, 3, 0, 3 * 8192 + 20);
    queue_request(OP_FREE, 1, 0, 8192 + 4096 + 20);
    queue_request(OP_FREE, 1, 0, 8192 + 16);
    queue_request(OP_DEFRAG, 0, 0, 0);
    queue_request(OP_RESET_STATS, 5, 0, 0);
    queue_request(OP_RESET_STATS, 0, 0, 0);
    queue_request(OP_FREE, 0, 0, 36);
    queue_request(OP_ALLOC, 2, 4080, 0);
    queue_request(OP_ALLOC, 2, 1, 0);
    queue_request(OP_FREE, 4, 0, 32767);
    queue_request(OP_ALLOC, 6, 65535, 0);
    queue_request(OP_DEFRAG, 3, 0, 0);
    queue_request(OP_FREE, 2, 0, 2 * 8192 + 16);
    wait_drained();

    // Pool 0 off, clamped pool 1, shrunk pool 2, defrag on: stale tags
    write_config(0, 16383, 100, POOL_BYTES, 1'b1);
    queue_request(OP_ALLOC, 3, 100, 0);
    queue_request(OP_ALLOC, 3, 3, 0);
    queue_request(OP_ALLOC, 5, 8, 0);
    queue_request(OP_DEFRAG, 3, 0, 0);
    queue_request(OP_FREE, 3, 0, 24592);
    queue_request(OP_FREE, 1, 0, 24708);
    queue_request(OP_DEFRAG, 3, 0, 0);
    queue_request(OP_FREE, 3, 0, 24708);
    queue_request(OP_ALLOC, 3, 8, 0);
    queue_request(OP_FREE, 3, 0, 24592);
    queue_request(OP_ALLOC, 2, 4, 0);
    queue_request(OP_DEFRAG, 0, 0, 0);
    queue_request(OP_ALLOC, 1, 8000, 0);
    queue_request(OP_FREE, 1, 0, 8208);
    queue_request(OP_RESET_STATS, 2, 0, 0);
    queue_request(OP_DEFRAG, 1, 0, 0);
    wait_drained();

    // Random phases, each under a fresh configuration
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      if (k == 0) write_config(POOL_BYTES, POOL_BYTES, POOL_BYTES, POOL_BYTES, 1'b1);
      else if (k == 1) write_config(1, 16383, 20, POOL_BYTES - 1, 1'b0);
      else write_config(pick_pool_size(), pick_pool_size(), pick_pool_size(),
                        pick_pool_size(), $urandom_range(0, 1));
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_request();
      wait_drained();
    end

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("multi_pool_bump_allocator_top_test passed");
    end else begin
      $display("multi_pool_bump_allocator_top_test failed");
    end
    $finish;
  end

endmodule
